FILE: rtl/core/modexp_pkg.sv
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths and reset value for the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int MOD_BITS = 31;
	localparam int EXP_BITS = 32;
	localparam int CNT_W    = $clog2(MOD_BITS);

	localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

endpackage

FILE: rtl/core/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: scans mul_b from its top bit, doubling and
// adding mul_a, and reduces the partial result below the modulus every cycle.
// ----------------------------------------------------------------------------
module modexp_mulmod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [modexp_pkg::MOD_BITS-1:0] mul_a,
	input  logic [modexp_pkg::MOD_BITS-1:0] mul_b,
	input  logic [modexp_pkg::MOD_BITS-1:0] modulus,
	output logic                          busy,
	output logic                          done,
	output logic [modexp_pkg::MOD_BITS-1:0] product
);
	import modexp_pkg::*;

	localparam int T_W = MOD_BITS + 2;

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MOD_BITS-1:0] a_q;
	logic [MOD_BITS-1:0] b_q;
	logic [MOD_BITS-1:0] r_q;

	logic [T_W-1:0]      sum;
	logic [T_W:0]        diff1;
	logic [T_W:0]        diff2;
	logic [MOD_BITS-1:0] r_next;
	logic                last;

	// partial result stays below the modulus, so 2r + a is below 3m
	always_comb begin
		sum   = {1'b0, r_q, 1'b0} + (b_q[MOD_BITS-1] ? {2'b00, a_q} : T_W'(0));
		diff1 = {1'b0, sum} - {3'b000, modulus};
		diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
		priority if (!diff2[T_W]) begin
			r_next = diff2[MOD_BITS-1:0];
		end else if (!diff1[T_W]) begin
			r_next = diff1[MOD_BITS-1:0];
		end else begin
			r_next = sum[MOD_BITS-1:0];
		end
	end

	assign last = (cnt_q == CNT_W'(MOD_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && last;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= mul_a;
			b_q <= mul_b;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= r_next;
			b_q <= {b_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign busy    = run_q;
	assign done    = done_q;
	assign product = r_q;

endmodule

FILE: rtl/core/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base_value ^ exponent_value mod modulus by right-to-left binary
// square-and-multiply on a shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One item is handled at a time. Each modular product runs on the bit-serial
// multiplier, which shifts one bit of its second operand per cycle. An item
// costs one product to reduce the base, one per set exponent bit and one
// squaring per exponent bit below the highest set bit. Control visits the
// decision state once per exponent bit up to the highest set bit, besides
// the steps that accept the item and hand it to the output register. A zero
// exponent returns 1, and a modulus below 2 returns 0. The result waits in an
// output register, so the next item can be accepted meanwhile. A result that
// is still waiting there delays the next one.
// Write the modulus only while the block is idle.
module modular_exponentiation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [modexp_pkg::MOD_BITS-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [modexp_pkg::MOD_BITS-1:0] base_value,
	input  logic [modexp_pkg::EXP_BITS-1:0] exponent_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [modexp_pkg::MOD_BITS-1:0] power_result
);
	import modexp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_SQR    = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t              state_q;
	logic [MOD_BITS-1:0] modulus_q;
	logic [EXP_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] sq_q;
	logic [MOD_BITS-1:0] result_q;
	logic                out_valid_q;

	logic                accept;
	logic                mod_ok;
	logic                mul_start;
	logic [MOD_BITS-1:0] mul_a;
	logic [MOD_BITS-1:0] mul_b;
	logic                mul_busy;
	logic                mul_done;
	logic [MOD_BITS-1:0] mul_product;
	logic                out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign mod_ok   = (modulus_q > MOD_BITS'(1));
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		mul_start = 1'b0;
		unique case (state_q)
			ST_IDLE:   mul_start = accept && mod_ok;
			ST_DECIDE: mul_start = (exp_q != '0);
			ST_MUL:    mul_start = mul_done && (exp_q[EXP_BITS-1:1] != '0);
			ST_REDUCE,
			ST_SQR,
			ST_DONE:   mul_start = 1'b0;
			default:   mul_start = 1'b0;
		endcase
	end

	// base reduction is 1 * base; a multiply takes the accumulator, else square
	always_comb begin
		priority if (state_q == ST_IDLE) begin
			mul_a = MOD_BITS'(1);
			mul_b = base_value;
		end else if (state_q == ST_DECIDE && exp_q[0]) begin
			mul_a = acc_q;
			mul_b = sq_q;
		end else begin
			mul_a = sq_q;
			mul_b = sq_q;
		end
	end

	modexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.modulus (modulus_q),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			modulus_q   <= MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				modulus_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= mod_ok ? ST_REDUCE : ST_DONE;
					end
				end
				ST_REDUCE: begin
					if (mul_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (exp_q == '0) begin
						state_q <= ST_DONE;
					end else if (exp_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= (exp_q[EXP_BITS-1:1] != '0) ? ST_SQR : ST_DONE;
					end
				end
				ST_SQR: begin
					if (mul_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					exp_q <= exponent_value;
					acc_q <= '0;
				end
			end
			ST_REDUCE: begin
				if (mul_done) begin
					sq_q  <= mul_product;
					acc_q <= MOD_BITS'(1);
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					acc_q <= mul_product;
				end
			end
			ST_SQR: begin
				if (mul_done) begin
					sq_q  <= mul_product;
					exp_q <= {1'b0, exp_q[EXP_BITS-1:1]};
				end
			end
			ST_DONE: begin
				if (out_free) begin
					result_q <= acc_q;
				end
			end
			ST_DECIDE: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign power_result = result_q;

	// the multiplier is never running while a new item can be taken
	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mul_busy)
		else $error("multiplier busy while idle");

	// a product only completes in a state that consumes it
	a_done_use: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier result dropped");

	// every delivered result is reduced below a valid modulus
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!mod_ok || result_q < modulus_q))
		else $error("result not reduced");

endmodule

FILE: dv/modular_exponentiation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Drives base/exponent items through the valid/ready input and checks every
// power_result against a square-and-multiply predictor kept in step with the
// modulus register. Covers the reset modulus, extreme and degenerate moduli,
// random moduli with random items, a long output stall and a steady stream.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;
	import modexp_pkg::*;

	typedef logic [MOD_BITS-1:0] residue_t;
	typedef logic [EXP_BITS-1:0] exponent_t;

	localparam int  CYCLE_LIMIT = 3_000_000;
	localparam int  SETTLE_CYCLES = 2100;
	localparam residue_t MODULUS_MAX = '1;

	logic      clk;
	logic      arst_n;
	logic      cfg_write;
	residue_t  cfg_data;
	logic      in_valid;
	logic      in_ready;
	residue_t  base_value;
	exponent_t exponent_value;
	logic      out_valid;
	logic      out_ready;
	residue_t  power_result;

	residue_t  modulus_now;
	residue_t  expected_powers[$];
	int        error_count;
	int        cycle_count;
	bit        idle_gaps;
	int        hold_cycles;

	modular_exponentiation dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.base_value    (base_value),
		.exponent_value(exponent_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.power_result  (power_result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("modular_exponentiation test failed");
		$finish;
	end

	function automatic residue_t predict_power(residue_t b, exponent_t e, residue_t m);
		logic [63:0] square;
		logic [63:0] product;
		logic [63:0] wide_mod;
		if (m < 2)
			return '0;
		wide_mod = 64'(m);
		square = 64'(b);
		product = 64'd1;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (e[i])
				product = (product * square) % wide_mod;
			square = (square * square) % wide_mod;
		end
		return residue_t'(product);
	endfunction

	// Hold out_ready low for a requested stretch, else, while idle gaps are on, stall in random bursts.
	initial begin
		out_ready = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				out_ready <= 1'b1;
			end else if (idle_gaps && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		residue_t wanted;
		if (arst_n && out_valid && out_ready) begin
			if (expected_powers.size() == 0) begin
				$error("power_result: expected none, actual %0d", power_result);
				error_count++;
			end else begin
				wanted = expected_powers.pop_front();
				if (power_result !== wanted) begin
					$error("power_result: expected %0d, actual %0d", wanted, power_result);
					error_count++;
				end
			end
		end
	end

	task automatic send_item(input residue_t b, input exponent_t e);
		if (idle_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		base_value <= b;
		exponent_value <= e;
		do @(posedge clk); while (!in_ready);
		expected_powers.insert(expected_powers.size(), predict_power(b, e, modulus_now));
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (expected_powers.size() != 0) @(posedge clk);
	endtask

	task automatic write_modulus(input residue_t m);
		wait_results();
		cfg_write <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_write <= 1'b0;
		modulus_now = m;
	endtask

	task automatic pick_random_item(output residue_t b, output exponent_t e);
		int width;
		case ($urandom_range(0, 9))
			0: b = '0;
			1: b = residue_t'(1);
			2: b = modulus_now - residue_t'(1);
			3: b = modulus_now;
			4: b = '1;
			default: b = residue_t'($urandom());
		endcase
		case ($urandom_range(0, 7))
			0: e = '0;
			1, 2: e = exponent_t'($urandom());
			3: e = '1;
			default: begin
				// keep most exponents short so the run stays brief
				width = $urandom_range(1, 10);
				e = exponent_t'($urandom()) & ((exponent_t'(1) << width) - exponent_t'(1));
			end
		endcase
	endtask

	task automatic pick_random_modulus(output residue_t m);
		case ($urandom_range(0, 3))
			0: m = residue_t'($urandom_range(2, 100));
			1: m = MODULUS_MAX - residue_t'($urandom_range(0, 1000));
			2: m = residue_t'($urandom_range(1000, 1 << 20));
			default: begin
				m = residue_t'($urandom());
				if (m < 2)
					m = residue_t'(2);
			end
		endcase
	endtask

	task automatic check_reset_modulus();
		send_item('0, '0);
		send_item('0, exponent_t'(5));
		send_item(residue_t'(5), '0);
		send_item('1, '1);
		send_item(residue_t'(2), exponent_t'(10));
		send_item(residue_t'(3), exponent_t'(1000000005));
		// unreduced base must match the reduced one
		send_item(MODULUS_RESET + residue_t'(3), exponent_t'(7));
		send_item(MODULUS_RESET, exponent_t'(3));
		send_item('1, exponent_t'(1));
		send_item(residue_t'(12345), exponent_t'(32'h8000_0000));
		send_item(residue_t'(7), exponent_t'(32'hAAAA_AAAA));
		send_item(MODULUS_RESET - residue_t'(1), exponent_t'(32'h5555_5555));
	endtask

	task automatic check_modulus_extremes();
		write_modulus(residue_t'(2));
		send_item(residue_t'(3), exponent_t'(5));
		send_item('0, '0);
		send_item('1, '1);
		write_modulus(MODULUS_MAX);
		send_item(MODULUS_MAX - residue_t'(1), '1);
		send_item(MODULUS_MAX, exponent_t'(5));
		send_item(residue_t'(123456789), exponent_t'(32'h0000_FFFF));
	endtask

	task automatic check_degenerate_moduli();
		write_modulus('0);
		send_item(residue_t'(9), '0);
		send_item('1, '1);
		write_modulus(residue_t'(1));
		send_item(residue_t'(4), '0);
		send_item(residue_t'(77), exponent_t'(3));
	endtask

	task automatic check_random_moduli();
		residue_t  m;
		residue_t  b;
		exponent_t e;
		for (int phase = 0; phase < 5; phase++) begin
			pick_random_modulus(m);
			write_modulus(m);
			repeat (40) begin
				pick_random_item(b, e);
				send_item(b, e);
			end
		end
	endtask

	task automatic check_output_backpressure();
		write_modulus(MODULUS_RESET);
		// stall the output long enough that the input backs up
		hold_cycles = 400;
		repeat (10)
			send_item(residue_t'($urandom()), exponent_t'($urandom_range(0, 3)));
		wait_results();
	endtask

	task automatic check_steady_stream();
		residue_t  m;
		residue_t  b;
		exponent_t e;
		idle_gaps = 1'b0;
		pick_random_modulus(m);
		write_modulus(m);
		repeat (60) begin
			pick_random_item(b, e);
			send_item(b, e);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		base_value = '0;
		exponent_value = '0;
		modulus_now = MODULUS_RESET;
		error_count = 0;
		cycle_count = 0;
		idle_gaps = 1'b1;
		hold_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_modulus();
		check_modulus_extremes();
		check_degenerate_moduli();
		check_random_moduli();
		check_output_backpressure();
		check_steady_stream();

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("modular_exponentiation test passed");
		else
			$display("modular_exponentiation test failed");
		$finish;
	end

endmodule
